FILE: rtl/ws_enc_pkg.sv
// shared types, constants and register codes of the four-lane led bit encoder
package ws_enc_pkg;

	localparam int LANES = 4;
	localparam int TIMER_BITS = 16;
	localparam int CFG_BITS = 16;
	localparam int BYTE_BITS = 32;
	localparam int OUT_BITS = 8;

	localparam logic [3:0] DRIVEN_MASK = 4'((1 << ((LANES > 4) ? 4 : LANES)) - 1);
	localparam logic [BYTE_BITS-1:0] SHIFT_KEEP = 32'hFEFE_FEFE;
	localparam logic [3:0] BITS_PER_GROUP = 4'd8;

	localparam logic [CFG_BITS-1:0] SHORT_HIGH_RESET = 16'd31;
	localparam logic [CFG_BITS-1:0] LONG_HIGH_RESET = 16'd63;
	localparam logic [CFG_BITS-1:0] PERIOD_RESET = 16'd99;
	localparam logic [3:0] LANE_ENABLE_RESET = 4'hF;

	typedef enum logic [1:0] {
		CFG_SHORT_HIGH = 2'd0,
		CFG_LONG_HIGH  = 2'd1,
		CFG_PERIOD     = 2'd2,
		CFG_LANE_EN    = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_SEND = 3'b010,
		PH_DONE = 3'b100
	} phase_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] short_high;
		logic [CFG_BITS-1:0] long_high;
		logic [CFG_BITS-1:0] period;
		logic [3:0]          lane_enable;
	} cfg_t;

	typedef struct packed {
		logic                 is_load;
		logic [BYTE_BITS-1:0] bytes;
		logic                 last;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

endpackage

FILE: rtl/ws_enc_front.sv
// front end: accepts and classifies input transactions into a two-entry queue
module ws_enc_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ws_enc_pkg::BYTE_BITS-1:0] s_tdata,
	input  logic                             s_tuser,
	input  logic                             s_tlast,
	output ws_enc_pkg::queue_head_t          head,
	input  logic                             pop
);

	ws_enc_pkg::item_t ent_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              push;
	logic              do_pop;

	assign s_tready = (cnt_q != 2'd2);
	assign push = s_tvalid && s_tready;
	assign do_pop = pop && (cnt_q != 2'd0);

	assign head.valid = (cnt_q != 2'd0);
	assign head.item = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q].is_load <= s_tuser;
			ent_q[wr_ptr_q].bytes <= s_tdata;
			ent_q[wr_ptr_q].last <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, do_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/ws_enc_back.sv
// back end: holding buffer, bit timer and lane shifter with registered result
module ws_enc_back #(
	parameter int TIMER_BITS = ws_enc_pkg::TIMER_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ws_enc_pkg::cfg_t                  cfg,
	input  ws_enc_pkg::queue_head_t           head,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ws_enc_pkg::OUT_BITS-1:0]   m_tdata
);

	localparam int CW = ((TIMER_BITS > ws_enc_pkg::CFG_BITS) ?
		TIMER_BITS : ws_enc_pkg::CFG_BITS) + 1;

	logic [ws_enc_pkg::BYTE_BITS-1:0] h_bytes_q, h_bytes_n;
	logic                             h_valid_q, h_valid_n;
	logic                             h_last_q, h_last_n;
	logic [ws_enc_pkg::BYTE_BITS-1:0] s_bytes_q, s_bytes_n;
	logic                             s_last_q, s_last_n;
	logic [3:0]                       bits_q, bits_n;
	logic [TIMER_BITS-1:0]            cnt_q, cnt_n;
	ws_enc_pkg::phase_t               phase_q, phase_n;
	logic                             m_valid_q;
	logic [ws_enc_pkg::OUT_BITS-1:0]  m_data_q;
	logic [3:0]                       levels;
	logic [3:0]                       ones;
	logic                             dropped;
	logic [CW-1:0]                    c_ext;
	logic                             fire;

	assign fire = head.valid && (!m_valid_q || m_tready);
	assign pop = fire;
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

	always_comb begin
		h_bytes_n = h_bytes_q;
		h_valid_n = h_valid_q;
		h_last_n = h_last_q;
		s_bytes_n = s_bytes_q;
		s_last_n = s_last_q;
		bits_n = bits_q;
		cnt_n = cnt_q;
		phase_n = phase_q;
		levels = 4'h0;
		ones = 4'h0;
		dropped = 1'b0;
		c_ext = '0;
		if (head.item.is_load) begin
			if (h_valid_q) begin
				dropped = 1'b1;
			end else begin
				h_bytes_n = head.item.bytes;
				h_last_n = head.item.last;
				h_valid_n = 1'b1;
			end
		end else begin
			if (phase_q != ws_enc_pkg::PH_SEND && h_valid_q) begin
				s_bytes_n = h_bytes_q;
				s_last_n = h_last_q;
				h_valid_n = 1'b0;
				bits_n = ws_enc_pkg::BITS_PER_GROUP;
				cnt_n = '0;
				phase_n = ws_enc_pkg::PH_SEND;
			end
			if (phase_n == ws_enc_pkg::PH_SEND) begin
				for (int i = 0; i < 4; i++) begin
					ones[i] = s_bytes_n[8*i+7];
				end
				c_ext = CW'(cnt_n);
				if (c_ext < CW'(cfg.short_high)) begin
					levels = 4'hF;
				end else if (c_ext < CW'(cfg.long_high)) begin
					levels = ones;
				end
				levels = levels & ws_enc_pkg::DRIVEN_MASK & cfg.lane_enable;
				if ((CW'(c_ext + CW'(1)) < CW'(cfg.period)) && (cnt_n != '1)) begin
					cnt_n = cnt_n + TIMER_BITS'(1);
				end else begin
					cnt_n = '0;
					s_bytes_n = (s_bytes_n << 1) & ws_enc_pkg::SHIFT_KEEP;
					bits_n = bits_n - 4'd1;
					if (bits_n == 4'd0) begin
						priority if (s_last_n) begin
							phase_n = ws_enc_pkg::PH_DONE;
						end else if (h_valid_n) begin
							s_bytes_n = h_bytes_n;
							s_last_n = h_last_n;
							h_valid_n = 1'b0;
							bits_n = ws_enc_pkg::BITS_PER_GROUP;
							phase_n = ws_enc_pkg::PH_SEND;
						end else begin
							phase_n = ws_enc_pkg::PH_IDLE;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			h_bytes_q <= h_bytes_n;
			m_data_q <= {1'b0, dropped, (phase_n == ws_enc_pkg::PH_DONE), !h_valid_n, levels};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_valid_q <= 1'b0;
			h_last_q <= 1'b0;
			s_bytes_q <= '0;
			s_last_q <= 1'b0;
			bits_q <= 4'd0;
			cnt_q <= '0;
			phase_q <= ws_enc_pkg::PH_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				h_valid_q <= h_valid_n;
				h_last_q <= h_last_n;
				s_bytes_q <= s_bytes_n;
				s_last_q <= s_last_n;
				bits_q <= bits_n;
				cnt_q <= cnt_n;
				phase_q <= phase_n;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/ws2812_four_lane_bit_encoder.sv
// top level of the four-lane single-wire led bit encoder
// Each input transaction is either one clock tick of the output waveform (s_tuser low) or a
// byte group for the one-entry holding buffer (s_tuser high, one byte per lane, s_tlast marks
// the final group of a frame). Every input transaction yields exactly one result transaction
// carrying the lane levels for that tick, the buffer-free and frame-done flags and a flag for a
// load that met a full buffer. One transaction is taken per clock cycle while the input queue
// has room; a result passes through the two-entry input queue and the output register, and
// the queue absorbs up to two transactions while the output side stalls. Timing registers
// (short high, long high, bit period in ticks, lane enable) are written through the cfg port;
// the user must write them only while no transaction is outstanding, as the block itself
// does not enforce this.
module ws2812_four_lane_bit_encoder #(
	parameter int TIMER_BITS = ws_enc_pkg::TIMER_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// byte_lane_a, byte_lane_b, byte_lane_c, byte_lane_d
	input  logic [ws_enc_pkg::BYTE_BITS-1:0]    s_tdata,
	// command
	input  logic                                s_tuser,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// line_levels, buffer_free, frame_done, load_dropped, zero pad
	output logic [ws_enc_pkg::OUT_BITS-1:0]     m_tdata,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [ws_enc_pkg::CFG_BITS-1:0]     cfg_data
);

	ws_enc_pkg::cfg_t        cfg_q;
	ws_enc_pkg::queue_head_t head;
	logic                    pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_high <= ws_enc_pkg::SHORT_HIGH_RESET;
			cfg_q.long_high <= ws_enc_pkg::LONG_HIGH_RESET;
			cfg_q.period <= ws_enc_pkg::PERIOD_RESET;
			cfg_q.lane_enable <= ws_enc_pkg::LANE_ENABLE_RESET;
		end else if (cfg_we) begin
			unique case (ws_enc_pkg::cfg_index_t'(cfg_index))
				ws_enc_pkg::CFG_SHORT_HIGH: cfg_q.short_high <= cfg_data;
				ws_enc_pkg::CFG_LONG_HIGH: cfg_q.long_high <= cfg_data;
				ws_enc_pkg::CFG_PERIOD: cfg_q.period <= cfg_data;
				ws_enc_pkg::CFG_LANE_EN: cfg_q.lane_enable <= cfg_data[3:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	ws_enc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.head     (head),
		.pop      (pop)
	);

	ws_enc_back #(
		.TIMER_BITS (TIMER_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_full_queue_means_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("queue full with no result waiting");

	a_levels_in_enabled_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:0] & ~cfg_q.lane_enable) == 4'h0)
		else $error("disabled lane driven");

	a_dropped_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6] |-> !m_tdata[4] && m_tdata[3:0] == 4'h0)
		else $error("dropped load with free buffer or lines high");

endmodule
